@@ rtl/fpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// fpwm_pkg
// Shared types and constants of the Fitch parsimony word merge block.
// ----------------------------------------------------------------------------
package fpwm_pkg;

  localparam int SETS    = 8;   // state sets per word
  localparam int SET_SH  = 3;   // log2 of SETS
  localparam int NIB_W   = 4;   // one state set
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 12;
  localparam int SET_W   = 32;
  localparam int WT_W    = 16;
  localparam int CHG_W   = 20;
  localparam int TOT_W   = 32;
  localparam int VAL_W   = IDX_W + SET_SH;  // store address before reduction
  localparam int NSTG    = 6;               // pipeline stages, output included

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_NODE = 2'd1,
    FUNC_ROOT = 2'd2,
    FUNC_IDLE = 2'd3
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [SET_W-1:0] left_set;
    logic [SET_W-1:0] right_set;
    logic [SET_W-1:0] root_set;
    logic [WT_W-1:0]  weight;
    logic             clear_total;
  } item_t;

endpackage

@@ rtl/fpwm_in_if.sv @@
// ----------------------------------------------------------------------------
// fpwm_in_if
// Input item channel: valid/ready handshake with the merge request payload.
// ----------------------------------------------------------------------------
interface fpwm_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpwm_pkg::FUNC_W-1:0] func;
  logic [fpwm_pkg::IDX_W-1:0]  index;
  logic [fpwm_pkg::SET_W-1:0]  left_set;
  logic [fpwm_pkg::SET_W-1:0]  right_set;
  logic [fpwm_pkg::SET_W-1:0]  root_set;
  logic [fpwm_pkg::WT_W-1:0]   weight;
  logic                        clear_total;

  modport source (
    output valid, func, index, left_set, right_set, root_set, weight, clear_total,
    input  ready
  );
  modport sink (
    input  valid, func, index, left_set, right_set, root_set, weight, clear_total,
    output ready
  );
endinterface

@@ rtl/fpwm_out_if.sv @@
// ----------------------------------------------------------------------------
// fpwm_out_if
// Result item channel: valid/ready handshake with merged word and lengths.
// ----------------------------------------------------------------------------
interface fpwm_out_if;
  logic                       valid;
  logic                       ready;
  logic [fpwm_pkg::SET_W-1:0] merged_set;
  logic [fpwm_pkg::CHG_W-1:0] word_changes;
  logic [fpwm_pkg::TOT_W-1:0] running_total;

  modport source (
    output valid, merged_set, word_changes, running_total,
    input  ready
  );
  modport sink (
    input  valid, merged_set, word_changes, running_total,
    output ready
  );
endinterface

@@ rtl/fpwm_weights.sv @@
// ----------------------------------------------------------------------------
// fpwm_weights
// Character weight store, one copy per nibble lane so that all lanes read
// in the same cycle. Writes go to every copy; reads are registered.
// ----------------------------------------------------------------------------
module fpwm_weights #(
  parameter int  MAX_CHARS = 4096,
  localparam int AW        = $clog2(MAX_CHARS)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fpwm_pkg::WT_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr [fpwm_pkg::SETS],
  output logic [fpwm_pkg::WT_W-1:0] rd_data [fpwm_pkg::SETS]
);

  for (genvar k = 0; k < fpwm_pkg::SETS; k++) begin : g_copy
    logic [fpwm_pkg::WT_W-1:0] mem [MAX_CHARS];
    logic [fpwm_pkg::WT_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_r <= mem[rd_addr[k]];
      end
    end

    assign rd_data[k] = rd_r;
  end

endmodule

@@ rtl/fitch_parsimony_word_merge.sv @@
// ----------------------------------------------------------------------------
// fitch_parsimony_word_merge
// Bit-parallel Fitch merge of packed 4-bit state sets with weighted change
// counting and a saturating tree length total.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while no stall reaches the input, and its
// result appears in the output register; under back-pressure the stages
// fill up and stall from the output backwards. The stages follow the
// address path: the word or character index is reduced modulo MAX_CHARS
// by a reciprocal multiply over two stages, the weight store is read in
// the next (one store copy per nibble lane, so all eight weights arrive
// together), then the lanes merge and sum their weights, and the last
// stage adds to the saturating total. Loads write the store in program order with the merges that follow them.
// ----------------------------------------------------------------------------
module fitch_parsimony_word_merge #(
  parameter int MAX_CHARS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  fpwm_in_if.sink     in_ch,
  fpwm_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_CHARS);
  localparam int SH = fpwm_pkg::VAL_W + AW;
  localparam int RW = fpwm_pkg::VAL_W + 1;
  localparam int PW = fpwm_pkg::VAL_W + RW;
  localparam int QW = fpwm_pkg::VAL_W + AW + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(MAX_CHARS) - 64'd1) / 64'(MAX_CHARS);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
  localparam logic [AW:0]   M_C     = (AW+1)'(MAX_CHARS);
  localparam int L1_W = fpwm_pkg::WT_W + 2;
  localparam int L2_W = fpwm_pkg::WT_W + 3;

  logic [fpwm_pkg::NSTG-1:0] vld_r, vld_nxt;
  logic [fpwm_pkg::NSTG:0]   stage_rdy;

  fpwm_pkg::item_t                s0_item_r, s1_item_r, s2_item_r, s3_item_r;
  logic [fpwm_pkg::IDX_W-1:0]     s0_index_r;
  logic [fpwm_pkg::VAL_W-1:0]     s0_num, s1_num_r;
  logic [PW-1:0]                  s0_prod;
  logic [fpwm_pkg::VAL_W-1:0]     q_nxt, s1_q_r;
  logic [QW-1:0]                  s1_qm, s1_diff;
  logic [AW-1:0]                  rem_nxt, s2_rem_r;

  logic [AW-1:0]                  rd_addr [fpwm_pkg::SETS];
  logic [fpwm_pkg::WT_W-1:0]      wt     [fpwm_pkg::SETS];
  logic                           wr_en;

  logic [fpwm_pkg::WT_W:0]        lane_w [fpwm_pkg::SETS];
  logic [L1_W-1:0]                sum1   [4];
  logic [L2_W-1:0]                sum2   [2];
  logic [fpwm_pkg::SET_W-1:0]     merged_nxt, s4_merged_r, out_merged_r;
  logic [fpwm_pkg::CHG_W-1:0]     chg_nxt, s4_chg_r, out_chg_r;
  logic                           s4_clear_r, s4_merge_r, s3_is_merge;
  logic [fpwm_pkg::TOT_W-1:0]     total_r, total_nxt;
  logic [fpwm_pkg::TOT_W:0]       total_sum;

  // ---- stage control ----
  always_comb begin
    stage_rdy[fpwm_pkg::NSTG] = out_ch.ready;
    for (int i = fpwm_pkg::NSTG - 1; i >= 0; i--) begin
      stage_rdy[i] = !vld_r[i] || stage_rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stage_rdy[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int i = 1; i < fpwm_pkg::NSTG; i++) begin
      if (stage_rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = stage_rdy[0];

  // ---- address reduction modulo MAX_CHARS ----
  always_comb begin
    if (s0_item_r.func == fpwm_pkg::FUNC_LOAD) begin
      s0_num = fpwm_pkg::VAL_W'(s0_index_r);
    end else begin
      s0_num = {s0_index_r, {fpwm_pkg::SET_SH{1'b0}}};
    end
    s0_prod = PW'(s0_num) * PW'(RECIP_C);
    q_nxt   = fpwm_pkg::VAL_W'(s0_prod >> SH);
  end

  always_comb begin
    s1_qm   = QW'(s1_q_r) * QW'(M_C);
    s1_diff = QW'(s1_num_r) - s1_qm;
    rem_nxt = s1_diff[AW-1:0];
  end

  always_comb begin
    logic [AW:0] t;
    t = '0;
    for (int k = 0; k < fpwm_pkg::SETS; k++) begin
      t = {1'b0, s2_rem_r} + (AW+1)'(k);
      if (t >= M_C) begin
        t = t - M_C;
      end
      rd_addr[k] = t[AW-1:0];
    end
  end

  assign wr_en = vld_r[2] && stage_rdy[3] && (s2_item_r.func == fpwm_pkg::FUNC_LOAD);

  fpwm_weights #(
    .MAX_CHARS (MAX_CHARS)
  ) u_weights (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s2_rem_r),
    .wr_data (s2_item_r.weight),
    .rd_en   (stage_rdy[3]),
    .rd_addr (rd_addr),
    .rd_data (wt)
  );

  // ---- nibble lanes ----
  always_comb begin
    logic                        is_root;
    logic [fpwm_pkg::NIB_W-1:0]  a, b, o, n1, m1, n2, m2;
    logic                        e1, e2;
    is_root     = (s3_item_r.func == fpwm_pkg::FUNC_ROOT);
    s3_is_merge = (s3_item_r.func == fpwm_pkg::FUNC_NODE) || is_root;
    merged_nxt  = '0;
    for (int k = 0; k < fpwm_pkg::SETS; k++) begin
      a  = s3_item_r.left_set [k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W];
      b  = s3_item_r.right_set[k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W];
      o  = s3_item_r.root_set [k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W];
      n1 = a & b;
      e1 = (n1 == '0);
      m1 = e1 ? (a | b) : n1;
      n2 = m1 & o;
      e2 = (n2 == '0);
      m2 = e2 ? (m1 | o) : n2;
      if (s3_is_merge) begin
        merged_nxt[k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W] = is_root ? m2 : m1;
      end
      priority if (s3_is_merge && e1 && is_root && e2) begin
        lane_w[k] = {wt[k], 1'b0};
      end else if ((s3_is_merge && e1) || (is_root && e2)) begin
        lane_w[k] = {1'b0, wt[k]};
      end else begin
        lane_w[k] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum1[i] = L1_W'(lane_w[2*i]) + L1_W'(lane_w[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      sum2[i] = L2_W'(sum1[2*i]) + L2_W'(sum1[2*i+1]);
    end
    chg_nxt = fpwm_pkg::CHG_W'(sum2[0]) + fpwm_pkg::CHG_W'(sum2[1]);
  end

  // ---- saturating total ----
  always_comb begin
    total_sum = {1'b0, (s4_clear_r ? '0 : total_r)} + (fpwm_pkg::TOT_W+1)'(s4_chg_r);
    total_nxt = total_sum[fpwm_pkg::TOT_W] ? '1 : total_sum[fpwm_pkg::TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (vld_r[4] && stage_rdy[5]) begin
      total_r <= total_nxt;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (stage_rdy[0]) begin
      s0_item_r.func        <= fpwm_pkg::func_t'(in_ch.func);
      s0_item_r.left_set    <= in_ch.left_set;
      s0_item_r.right_set   <= in_ch.right_set;
      s0_item_r.root_set    <= in_ch.root_set;
      s0_item_r.weight      <= in_ch.weight;
      s0_item_r.clear_total <= in_ch.clear_total;
      s0_index_r            <= in_ch.index;
    end
    if (stage_rdy[1]) begin
      s1_item_r <= s0_item_r;
      s1_num_r  <= s0_num;
      s1_q_r    <= q_nxt;
    end
    if (stage_rdy[2]) begin
      s2_item_r <= s1_item_r;
      s2_rem_r  <= rem_nxt;
    end
    if (stage_rdy[3]) begin
      s3_item_r <= s2_item_r;
    end
    if (stage_rdy[4]) begin
      s4_merged_r <= merged_nxt;
      s4_chg_r    <= chg_nxt;
      s4_clear_r  <= s3_item_r.clear_total;
      s4_merge_r  <= s3_is_merge;
    end
    if (stage_rdy[5]) begin
      out_merged_r <= s4_merged_r;
      out_chg_r    <= s4_chg_r;
    end
  end

  assign out_ch.valid         = vld_r[5];
  assign out_ch.merged_set    = out_merged_r;
  assign out_ch.word_changes  = out_chg_r;
  assign out_ch.running_total = total_r;

`ifndef SYNTHESIS
  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && stage_rdy[5] && !s4_clear_r) |=> (total_r >= $past(total_r)))
    else $error("running total fell without a clear");

  a_total_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && stage_rdy[5] && !s4_clear_r && (total_r == '1)) |=> (total_r == '1))
    else $error("saturated total left saturation");

  a_no_chg_load: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !s4_merge_r) |-> ((s4_chg_r == '0) && (s4_merged_r == '0)))
    else $error("non-merge item carries changes or a set");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_rdy[0] |-> ((&vld_r) && !out_ch.ready))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

@@ tb/tb_fitch_parsimony_word_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fitch_parsimony_word_merge
// Self-checking testbench of the Fitch parsimony word merge block.
// A directed table covers reset state, loads, extreme words, index
// wrap-around, clear requests and a long run of heavy root merges. Random
// items follow: weight-group loads, node and root merges over loaded groups,
// and idle codes. Results are checked against typed table rows or a local
// predictor, under random stalls on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_fitch_parsimony_word_merge;

  localparam int MAX_CHARS  = 4096;
  localparam int GROUPS     = MAX_CHARS / fpwm_pkg::SETS;
  localparam int RAND_ITEMS = 420;
  localparam int HOLD_LEN   = 200;
  localparam int WDOG_LIMIT = 4000;
  localparam int MAX_SHOWN  = 10;
  localparam int DIR_ROWS   = 17;

  typedef struct packed {
    fpwm_pkg::func_t              func;
    logic [fpwm_pkg::IDX_W-1:0]   index;
    logic [fpwm_pkg::SET_W-1:0]   left_set;
    logic [fpwm_pkg::SET_W-1:0]   right_set;
    logic [fpwm_pkg::SET_W-1:0]   root_set;
    logic [fpwm_pkg::WT_W-1:0]    weight;
    logic                         clear_total;
  } merge_req_t;

  typedef struct packed {
    logic [fpwm_pkg::SET_W-1:0] merged_set;
    logic [fpwm_pkg::CHG_W-1:0] word_changes;
    logic [fpwm_pkg::TOT_W-1:0] running_total;
  } merge_res_t;

  typedef struct packed {
    merge_req_t req;
    logic [15:0] rep;
    logic        idx_step;
    logic        typed;
    merge_res_t  res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fpwm_in_if  in_if ();
  fpwm_out_if out_if ();

  fitch_parsimony_word_merge #(.MAX_CHARS(MAX_CHARS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state
  logic [fpwm_pkg::WT_W-1:0]  wt_mem [MAX_CHARS];
  bit [MAX_CHARS-1:0]         wt_written;
  bit [GROUPS-1:0]            group_full;
  int                         full_groups [$];
  logic [fpwm_pkg::TOT_W-1:0] tree_len;

  merge_res_t expected_results [$];

  int  err_cnt;
  int  n_items;
  int  n_loads;
  int  n_merges;
  int  n_sat;
  int  snd_idle;
  int  rcv_idle;
  bit  hold_req;

  // --------------------------------------------------------------------------
  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{fpwm_pkg::FUNC_IDLE, 12'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}, 16'd1, 1'b0,
      1'b1, '{32'h0, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_LOAD, 12'd0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0}, 16'd8, 1'b1,
      1'b1, '{32'h0, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_LOAD, 12'd4088, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}, 16'd8, 1'b1,
      1'b1, '{32'h0, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_NODE, 12'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 16'h0, 1'b0},
      16'd1, 1'b0, 1'b1, '{32'hFFFFFFFF, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_NODE, 12'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}, 16'd1, 1'b0,
      1'b1, '{32'h0, 20'd524280, 32'd524280}},
    '{'{fpwm_pkg::FUNC_NODE, 12'd511, 32'h11111111, 32'h22222222, 32'h0, 16'h0, 1'b0},
      16'd1, 1'b0, 1'b1, '{32'h33333333, 20'd0, 32'd524280}},
    '{'{fpwm_pkg::FUNC_ROOT, 12'd512, 32'h11111111, 32'h22222222, 32'h88888888,
        16'h0, 1'b0},
      16'd1, 1'b0, 1'b1, '{32'hBBBBBBBB, 20'd1048560, 32'd1572840}},
    '{'{fpwm_pkg::FUNC_ROOT, 12'd4095, 32'h77777777, 32'h77777777, 32'h88888888,
        16'h0, 1'b0},
      16'd1, 1'b0, 1'b1, '{32'hFFFFFFFF, 20'd0, 32'd1572840}},
    '{'{fpwm_pkg::FUNC_LOAD, 12'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1}, 16'd1, 1'b0,
      1'b1, '{32'h0, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_NODE, 12'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}, 16'd1, 1'b0,
      1'b1, '{32'h0, 20'd458745, 32'd458745}},
    '{'{fpwm_pkg::FUNC_LOAD, 12'd0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0}, 16'd1, 1'b0,
      1'b1, '{32'h0, 20'd0, 32'd458745}},
    '{'{fpwm_pkg::FUNC_IDLE, 12'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1}, 16'd1, 1'b0,
      1'b1, '{32'h0, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_IDLE, 12'd4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        16'hFFFF, 1'b0},
      16'd1, 1'b0, 1'b1, '{32'h0, 20'd0, 32'd0}},
    // build up a large total
    '{'{fpwm_pkg::FUNC_ROOT, 12'd0, 32'h11111111, 32'h22222222, 32'h44444444,
        16'h0, 1'b0},
      16'd40, 1'b0, 1'b0, '{32'h0, 20'd0, 32'd0}},
    '{'{fpwm_pkg::FUNC_ROOT, 12'd0, 32'h11111111, 32'h22222222, 32'h44444444,
        16'h0, 1'b0},
      16'd1, 1'b0, 1'b1, '{32'h77777777, 20'd1048560, 32'd42990960}},
    '{'{fpwm_pkg::FUNC_NODE, 12'd3584, 32'h5A5A5A5A, 32'hA5A5A5A5, 32'h0, 16'h0, 1'b1},
      16'd1, 1'b0, 1'b1, '{32'hFFFFFFFF, 20'd524280, 32'd524280}},
    '{'{fpwm_pkg::FUNC_NODE, 12'd1536, 32'h12345678, 32'h0F0F0F0F, 32'h0, 16'h0, 1'b0},
      16'd1, 1'b0, 1'b0, '{32'h0, 20'd0, 32'd0}}
  };

  // --------------------------------------------------------------------------
  function automatic logic [fpwm_pkg::SET_W-1:0] fitch_merge(
      input logic [fpwm_pkg::SET_W-1:0] x,
      input logic [fpwm_pkg::SET_W-1:0] y,
      input logic [fpwm_pkg::IDX_W-1:0] word,
      inout logic [31:0] chg);
    logic [fpwm_pkg::SET_W-1:0] z;
    logic [fpwm_pkg::NIB_W-1:0] a, b, n;
    int addr;
    z = '0;
    for (int k = 0; k < fpwm_pkg::SETS; k++) begin
      a = x[k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W];
      b = y[k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W];
      n = a & b;
      if (n == '0) begin
        addr = (int'(word) * fpwm_pkg::SETS + k) % MAX_CHARS;
        n    = a | b;
        chg  = chg + 32'(wt_mem[addr]);
      end
      z[k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W] = n;
    end
    return z;
  endfunction

  function automatic merge_res_t fitch_predict(input merge_req_t r);
    merge_res_t res;
    logic [31:0] chg;
    logic [fpwm_pkg::TOT_W:0] sum;
    int a, g;
    res = '0;
    chg = '0;
    if (r.clear_total) tree_len = '0;
    if (r.func == fpwm_pkg::FUNC_LOAD) begin
      a = int'(r.index) % MAX_CHARS;
      wt_mem[a] = r.weight;
      wt_written[a] = 1'b1;
      g = a / fpwm_pkg::SETS;
      if (!group_full[g] && (&wt_written[g*fpwm_pkg::SETS +: fpwm_pkg::SETS])) begin
        group_full[g] = 1'b1;
        full_groups.push_back(g);
      end
    end else if (r.func == fpwm_pkg::FUNC_NODE || r.func == fpwm_pkg::FUNC_ROOT) begin
      res.merged_set = fitch_merge(r.left_set, r.right_set, r.index, chg);
      if (r.func == fpwm_pkg::FUNC_ROOT)
        res.merged_set = fitch_merge(res.merged_set, r.root_set, r.index, chg);
      sum = {1'b0, tree_len} + {1'b0, chg};
      tree_len = sum[fpwm_pkg::TOT_W] ? '1 : sum[fpwm_pkg::TOT_W-1:0];
    end
    res.word_changes  = chg[fpwm_pkg::CHG_W-1:0];
    res.running_total = tree_len;
    return res;
  endfunction

  function automatic logic [fpwm_pkg::SET_W-1:0] rand_sets();
    logic [fpwm_pkg::SET_W-1:0] w;
    w = $urandom;
    if ($urandom_range(1) == 1)
      for (int k = 0; k < fpwm_pkg::SETS; k++)
        w[k*fpwm_pkg::NIB_W +: fpwm_pkg::NIB_W] = 4'b0001 << $urandom_range(3);
    return w;
  endfunction

  task automatic note_error(input string msg);
    if (err_cnt < MAX_SHOWN) $display("ERROR %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic offer_item(input merge_req_t r, input bit typed, input merge_res_t want);
    merge_res_t pred;
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= r.func;
    in_if.index       <= r.index;
    in_if.left_set    <= r.left_set;
    in_if.right_set   <= r.right_set;
    in_if.root_set    <= r.root_set;
    in_if.weight      <= r.weight;
    in_if.clear_total <= r.clear_total;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = fitch_predict(r);
    expected_results.push_back(typed ? want : pred);
    n_items++;
    if (r.func == fpwm_pkg::FUNC_LOAD) n_loads++;
    if (r.func == fpwm_pkg::FUNC_NODE || r.func == fpwm_pkg::FUNC_ROOT) n_merges++;
  endtask

  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_if.valid       <= 1'b0;
    in_if.func        <= fpwm_pkg::FUNC_IDLE;
    in_if.index       <= '0;
    in_if.left_set    <= '0;
    in_if.right_set   <= '0;
    in_if.root_set    <= '0;
    in_if.weight      <= '0;
    in_if.clear_total <= 1'b0;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    merge_res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.merged_set, out_if.word_changes, out_if.running_total};
      if (out_if.running_total == '1) n_sat++;
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result set=%h chg=%0d tot=%h",
                             got.merged_set, got.word_changes, got.running_total));
      end else begin
        want = expected_results.pop_front();
        if (got.merged_set !== want.merged_set || got.word_changes !== want.word_changes ||
            got.running_total !== want.running_total)
          note_error($sformatf("exp set=%h chg=%0d tot=%h, got set=%h chg=%0d tot=%h",
                               want.merged_set, want.word_changes, want.running_total,
                               got.merged_set, got.word_changes, got.running_total));
      end
    end
  end

  // watchdog: cycles without any accepted item
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
    $display("fitch_parsimony_word_merge regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  initial begin
    merge_req_t s;
    int burst [$];
    int roll, g;
    err_cnt  = 0;
    n_items  = 0;
    n_loads  = 0;
    n_merges = 0;
    n_sat    = 0;
    tree_len = '0;
    wt_written = '0;
    group_full = '0;
    hold_req = 1'b0;
    snd_idle = 37;
    rcv_idle = 76;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[r]) begin
      for (int i = 0; i < int'(dir_table[r].rep); i++) begin
        s = dir_table[r].req;
        if (dir_table[r].idx_step)
          s.index = fpwm_pkg::IDX_W'(int'(dir_table[r].req.index) + i);
        offer_item(s, dir_table[r].typed, dir_table[r].res);
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        snd_idle = 76;
        rcv_idle = 37;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
        hold_req = 1'b1;
      end
      if (burst.size() == 0 && $urandom_range(99) < 6) begin
        g = int'($urandom_range(GROUPS - 1));
        for (int k = 0; k < fpwm_pkg::SETS; k++) burst.push_back(g * fpwm_pkg::SETS + k);
      end
      s.left_set    = rand_sets();
      s.right_set   = rand_sets();
      s.root_set    = rand_sets();
      s.weight      = fpwm_pkg::WT_W'(($urandom_range(3) == 0) ?
                                      $urandom_range(15) : $urandom);
      s.clear_total = ($urandom_range(31) == 0);
      s.index       = fpwm_pkg::IDX_W'($urandom_range(MAX_CHARS - 1));
      roll = $urandom_range(99);
      if (burst.size() != 0) begin
        s.func  = fpwm_pkg::FUNC_LOAD;
        s.index = fpwm_pkg::IDX_W'(burst.pop_front());
      end else if (roll < 12) begin
        s.func = fpwm_pkg::FUNC_LOAD;
      end else if (roll < 17) begin
        s.func = fpwm_pkg::FUNC_IDLE;
      end else begin
        s.func  = ($urandom_range(1) == 1) ? fpwm_pkg::FUNC_ROOT : fpwm_pkg::FUNC_NODE;
        g       = full_groups[$urandom_range(full_groups.size() - 1)];
        s.index = fpwm_pkg::IDX_W'(g + GROUPS * int'($urandom_range(
                    MAX_CHARS / GROUPS / fpwm_pkg::SETS * fpwm_pkg::SETS - 1)));
      end
      offer_item(s, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (fpwm_pkg::NSTG * 4) @(posedge clk);

    $display("covered %0d items: %0d loads, %0d merges, %0d saturated totals",
             n_items, n_loads, n_merges, n_sat);
    $display("weight groups loaded: %0d, mismatches: %0d", full_groups.size(), err_cnt);
    if (err_cnt == 0) begin
      $display("fitch_parsimony_word_merge regression: pass");
    end else begin
      $display("fitch_parsimony_word_merge regression: fail");
    end
    $finish;
  end

endmodule
